FILE: hdl/mfd_pkg.sv
// Shared types and constants for the multichannel frame deframer.
package mfd_pkg;

  // Field widths
  localparam int unsigned ChanW    = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OffW     = 12;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned LenW     = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Register reset values
  localparam logic [ByteW-1:0] HeadReset = 8'd170;
  localparam logic [ByteW-1:0] TailReset = 8'd85;
  localparam logic [ByteW-1:0] MaskReset = 8'd240;
  localparam logic [ByteW-1:0] IdReset   = 8'd0;
  localparam logic [LenW-1:0]  LenReset  = 12'd64;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD_VALUE     = 3'd0,
    CFG_TAIL_VALUE     = 3'd1,
    CFG_ID_MASK        = 3'd2,
    CFG_ID_VALUE       = 3'd3,
    CFG_TYPE_SUPPORTED = 3'd4,
    CFG_PAYLOAD_LEN    = 3'd5
  } cfg_idx_e;

  // Per-channel parse phase
  typedef enum logic [3:0] {
    PH_HEAD  = 4'd0,
    PH_ID    = 4'd1,
    PH_IDX1  = 4'd2,
    PH_IDX2  = 4'd3,
    PH_DATA  = 4'd4,
    PH_TAIL0 = 4'd5,
    PH_TAIL1 = 4'd6,
    PH_TAIL2 = 4'd7,
    PH_TAIL3 = 4'd8
  } phase_e;

  // Per-byte status code
  typedef enum logic [StatusW-1:0] {
    ST_IGNORED  = 3'd0,
    ST_STORED   = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_BAD_TAIL = 3'd4
  } status_e;

  // One result word
  typedef struct packed {
    logic [ChanW-1:0] out_chan;
    logic [ByteW-1:0] out_byte;
    logic [OffW-1:0]  frame_offset;
    status_e          status;
  } res_t;

endpackage

FILE: hdl/mfd_in_if.sv
// Input byte channel: valid/ready with channel number and raw byte.
interface mfd_in_if;
  import mfd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] chan;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output chan, output in_byte, input ready);
  modport sink   (input valid, input chan, input in_byte, output ready);
endinterface

FILE: hdl/mfd_out_if.sv
// Result channel: valid/ready with channel, byte, frame offset and status.
interface mfd_out_if;
  import mfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ChanW-1:0]   out_chan;
  logic [ByteW-1:0]   out_byte;
  logic [OffW-1:0]    frame_offset;
  logic [StatusW-1:0] status;

  modport source (output valid, output out_chan, output out_byte, output frame_offset,
                  output status, input ready);
  modport sink   (input valid, input out_chan, input out_byte, input frame_offset,
                  input status, output ready);
endinterface

FILE: hdl/multichannel_frame_deframer_core.sv
// Multichannel frame deframer: per-channel frame parser with registered result.
//
//  Channel  | Dir | Word contents                             | Handshake
//  ---------+-----+-------------------------------------------+-----------
//  in_i     | in  | chan, in_byte                             | valid/ready
//  out_o    | out | out_chan, out_byte, frame_offset, status  | valid/ready
//  cfg_*    | in  | cfg_idx_i, cfg_data_i                     | cfg_we_i only
//
// One byte per cycle while in_i.ready is high: a word is parsed in the
// cycle it is accepted, the channel state updates at that edge and the
// result lands in the output register (or the skid register while the
// output is held), so the next byte of the same channel sees the new state.
// A two-entry output stage (result register plus skid register) keeps
// in_i.ready registered; it drops only when both entries hold results.
// Reset puts every channel into head hunting and restores register defaults.
module multichannel_frame_deframer_core #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [mfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mfd_pkg::CfgDataW-1:0] cfg_data_i,
  mfd_in_if.sink                  in_i,
  mfd_out_if.source               out_o
);
  import mfd_pkg::*;

  // Only channel numbers the chan field can carry need state
  localparam int unsigned NumCh   = (CHANNELS < (1 << ChanW)) ? CHANNELS : (1 << ChanW);
  localparam int unsigned ChIdxW  = (NumCh > 1) ? $clog2(NumCh) : 1;
  localparam int unsigned MaxPay  = MAX_FRAME - 8;
  localparam logic [LenW-1:0] LeftReset =
      (32'(LenReset) > MaxPay) ? LenW'(MaxPay) : LenReset;

  // Configuration registers
  logic [ByteW-1:0] head_value_q, tail_value_q, id_mask_q, id_value_q;
  logic             type_supported_q;
  logic [LenW-1:0]  payload_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_value_q     <= HeadReset;
      tail_value_q     <= TailReset;
      id_mask_q        <= MaskReset;
      id_value_q       <= IdReset;
      type_supported_q <= 1'b1;
      payload_len_q    <= LenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HEAD_VALUE:     head_value_q     <= cfg_data_i[ByteW-1:0];
        CFG_TAIL_VALUE:     tail_value_q     <= cfg_data_i[ByteW-1:0];
        CFG_ID_MASK:        id_mask_q        <= cfg_data_i[ByteW-1:0];
        CFG_ID_VALUE:       id_value_q       <= cfg_data_i[ByteW-1:0];
        CFG_TYPE_SUPPORTED: type_supported_q <= cfg_data_i[0];
        CFG_PAYLOAD_LEN:    payload_len_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective payload length: at least one, at most what fits in a frame
  logic [LenW-1:0] eff_len;
  always_comb begin
    if (payload_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(payload_len_q) > MaxPay) begin
      eff_len = LenW'(MaxPay);
    end else begin
      eff_len = payload_len_q;
    end
  end

  // Per-channel parse state
  phase_e          phase_q [NumCh];
  logic [OffW-1:0] offset_q[NumCh];
  logic [LenW-1:0] left_q  [NumCh];

  logic            in_acc;
  logic            in_range;
  logic [ChIdxW-1:0] ch_idx;
  phase_e          ph;
  logic [OffW-1:0] off_cur;
  logic [LenW-1:0] left_cur;
  phase_e          phase_d;
  logic [OffW-1:0] offset_d;
  logic [LenW-1:0] left_d;
  logic            store;
  res_t            res;

  assign in_range = (32'(in_i.chan) < NumCh);
  assign ch_idx   = in_i.chan[ChIdxW-1:0];
  assign ph       = phase_q[ch_idx];
  assign off_cur  = offset_q[ch_idx];
  assign left_cur = left_q[ch_idx];

  // Parse one byte against its channel's state
  always_comb begin
    phase_d  = ph;
    offset_d = off_cur;
    left_d   = left_cur;
    store    = 1'b0;
    res.out_chan     = in_i.chan;
    res.out_byte     = in_i.in_byte;
    res.frame_offset = '0;
    res.status       = ST_IGNORED;
    if (in_range) begin
      case (ph)
        PH_HEAD: begin
          if (in_i.in_byte == head_value_q) begin
            offset_d = '0;
            left_d   = eff_len;
            store    = 1'b1;
            phase_d  = PH_ID;
          end
        end
        PH_ID: begin
          if (type_supported_q && ((in_i.in_byte & id_mask_q) == id_value_q)) begin
            store   = 1'b1;
            phase_d = PH_IDX1;
          end else begin
            res.status = ST_BAD_ID;
            phase_d    = PH_HEAD;
          end
        end
        PH_IDX1: begin
          store   = 1'b1;
          phase_d = PH_IDX2;
        end
        PH_IDX2: begin
          store   = 1'b1;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          store = 1'b1;
          if (left_cur <= LenW'(1)) begin
            left_d  = eff_len;
            phase_d = PH_TAIL0;
          end else begin
            left_d = left_cur - LenW'(1);
          end
        end
        PH_TAIL0: begin
          store   = 1'b1;
          phase_d = PH_TAIL1;
        end
        PH_TAIL1: begin
          store   = 1'b1;
          phase_d = PH_TAIL2;
        end
        PH_TAIL2: begin
          store   = 1'b1;
          phase_d = PH_TAIL3;
        end
        PH_TAIL3: begin
          phase_d = PH_HEAD;
          if (in_i.in_byte == tail_value_q) begin
            store = 1'b1;
          end else begin
            res.status = ST_BAD_TAIL;
          end
        end
        default: phase_d = PH_HEAD;
      endcase
      if (store) begin
        // head byte restarts the count, so its stored offset is zero
        res.frame_offset = (ph == PH_HEAD) ? '0 : off_cur;
        res.status       = (ph == PH_TAIL3) ? ST_COMPLETE : ST_STORED;
        offset_d         = res.frame_offset + OffW'(1);
      end
    end
  end

  // Channel state update on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        phase_q[i]  <= PH_HEAD;
        offset_q[i] <= '0;
        left_q[i]   <= LeftReset;
      end
    end else if (in_acc && in_range) begin
      for (int i = 0; i < NumCh; i++) begin
        if (ch_idx == ChIdxW'(i)) begin
          phase_q[i]  <= phase_d;
          offset_q[i] <= offset_d;
          left_q[i]   <= left_d;
        end
      end
    end
  end

  // Output register plus skid register
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic out_pop;

  assign in_i.ready = !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_pop    = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_pop) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_chan     = out_q.out_chan;
  assign out_o.out_byte     = out_q.out_byte;
  assign out_o.frame_offset = out_q.frame_offset;
  assign out_o.status       = out_q.status;

`ifndef SYNTHESIS
  // skid entry is only used behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // a stalled result is not lost
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("result dropped while stalled");

  // dropped or ignored bytes carry no frame offset
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (res.status == ST_IGNORED || res.status == ST_BAD_ID ||
                res.status == ST_BAD_TAIL)) |-> (res.frame_offset == '0))
    else $error("non-zero offset on a byte that was not stored");

  // a hunting channel only leaves hunting on the head value
  a_hunt_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_range && ph == PH_HEAD && in_i.in_byte != head_value_q)
      |-> (res.status == ST_IGNORED && phase_d == PH_HEAD))
    else $error("frame started without head byte");
`endif

endmodule
